@@ design/wqsr_pkg.sv @@
// Shared types, constants and the microcode table for the stochastic-round
// weight quantizer. No dependencies.
package wqsr_pkg;

  // Level count default and fixed field widths
  localparam int NUM_LEVELS_DEF = 16;
  localparam int TARGET_W       = 20;
  localparam int RAND_W         = 16;
  localparam int LEVEL_OUT_W    = 4;
  localparam int COEF_W         = 32;
  localparam int ADDR_W         = 4;

  // Datapath widths
  localparam int MUL_A_W = 33;                 // signed coefficient or span slice
  localparam int MUL_B_W = 18;                 // signed d, d*d or random fraction
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 60;
  localparam int LVL_W   = 42;                 // saturated level value, +-2^40
  localparam int SPLIT   = 21;                 // span split point for the cross-multiply

  localparam logic signed [ACC_W-1:0] LVL_SAT = 60'sh100_0000_0000;

  // Register indexes
  localparam logic [1:0] REG_COEF_CONST  = 2'd0;
  localparam logic [1:0] REG_COEF_LINEAR = 2'd1;
  localparam logic [1:0] REG_COEF_SQUARE = 2'd2;

  localparam logic signed [COEF_W-1:0] COEF_CONST_RST  = 32'sd6156495;
  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 32'sd5330983;
  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -32'sd104683;

  // Microprogram addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LVL_MUL_SQ  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LVL_MUL_LIN = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LVL_SUM     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LVL_TEST    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RND_MUL_LO  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RND_MUL_HI  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RND_SUM     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RND_TEST    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT        = 4'd9;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MS_NONE,
    MS_SQ,
    MS_LIN,
    MS_SPAN_LO,
    MS_SPAN_HI
  } mul_sel_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    AO_HOLD,
    AO_LOAD_CONST,   // acc = coef_const + prod
    AO_LOAD_PROD,    // acc = prod
    AO_ADD_SHIFT     // acc = acc + (prod << SPLIT)
  } acc_op_t;

  // Branch / sequencing kind
  typedef enum logic [2:0] {
    BR_START,        // wait for an input transfer
    BR_NEXT,         // go to the next field
    BR_LEVEL,        // level test: loop, round or finish
    BR_ROUND,        // resolve stochastic rounding
    BR_EMIT          // wait for the output register
  } branch_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              lvl_load;
    branch_t           br;
    logic [STEP_W-1:0] next;
  } ucode_t;

  typedef struct packed {
    logic below;       // current level value lies below the target
    logic at_top;      // current level is the top level
    logic have_last;   // some earlier level lay below the target
  } dp_stat_t;

  // Microprogram
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{MS_NONE, AO_HOLD, 1'b0, BR_START, STEP_LVL_MUL_SQ};
    case (step)
      STEP_IDLE:        w = '{MS_NONE,    AO_HOLD,       1'b0, BR_START, STEP_LVL_MUL_SQ};
      STEP_LVL_MUL_SQ:  w = '{MS_SQ,      AO_HOLD,       1'b0, BR_NEXT,  STEP_LVL_MUL_LIN};
      STEP_LVL_MUL_LIN: w = '{MS_LIN,     AO_LOAD_CONST, 1'b0, BR_NEXT,  STEP_LVL_SUM};
      STEP_LVL_SUM:     w = '{MS_NONE,    AO_HOLD,       1'b1, BR_NEXT,  STEP_LVL_TEST};
      STEP_LVL_TEST:    w = '{MS_NONE,    AO_HOLD,       1'b0, BR_LEVEL, STEP_LVL_MUL_SQ};
      STEP_RND_MUL_LO:  w = '{MS_SPAN_LO, AO_HOLD,       1'b0, BR_NEXT,  STEP_RND_MUL_HI};
      STEP_RND_MUL_HI:  w = '{MS_SPAN_HI, AO_LOAD_PROD,  1'b0, BR_NEXT,  STEP_RND_SUM};
      STEP_RND_SUM:     w = '{MS_NONE,    AO_ADD_SHIFT,  1'b0, BR_NEXT,  STEP_RND_TEST};
      STEP_RND_TEST:    w = '{MS_NONE,    AO_HOLD,       1'b0, BR_ROUND, STEP_EMIT};
      STEP_EMIT:        w = '{MS_NONE,    AO_HOLD,       1'b0, BR_EMIT,  STEP_IDLE};
      default:          w = '{MS_NONE,    AO_HOLD,       1'b0, BR_START, STEP_LVL_MUL_SQ};
    endcase
    return w;
  endfunction

endpackage

@@ design/wqsr_seq.sv @@
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on wqsr_pkg.
module wqsr_seq import wqsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     out_free,
  input  dp_stat_t stat,
  output ucode_t   ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign ctrl = ucode_rom(step);

  // Pick the next step from the branch kind of the current word
  always_comb begin
    step_next = step;
    case (ctrl.br)
      BR_START: begin
        if (start) step_next = ctrl.next;
      end
      BR_NEXT, BR_ROUND: begin
        step_next = ctrl.next;
      end
      BR_LEVEL: begin
        if (stat.below && !stat.at_top) begin
          step_next = ctrl.next;
        end else if (stat.below || !stat.have_last) begin
          step_next = STEP_EMIT;
        end else begin
          step_next = step + 4'd1;
        end
      end
      BR_EMIT: begin
        if (out_free) step_next = ctrl.next;
      end
      default: step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ design/wqsr_dp.sv @@
// Datapath: shared multiplier, accumulator, level saturation and the
// cross-multiply rounding test. Controlled by wqsr_seq; depends on wqsr_pkg.
module wqsr_dp import wqsr_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ucode_t                   ctrl,
  input  logic                     start,
  input  logic [TARGET_W-1:0]      target_in,
  input  logic [RAND_W-1:0]        rand_in,
  input  logic signed [COEF_W-1:0] coef_const,
  input  logic signed [COEF_W-1:0] coef_linear,
  input  logic signed [COEF_W-1:0] coef_square,
  output dp_stat_t                 stat,
  output logic [LEVEL_OUT_W-1:0]   result
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam logic [LW-1:0] TOP = LW'(NUM_LEVELS - 1);

  logic [TARGET_W-1:0]      target;
  logic [RAND_W-1:0]        rnd;
  logic [LW-1:0]            d;
  logic [2*LW-1:0]          dsq;
  logic                     have_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [LVL_W-1:0]  lvl;
  logic signed [LVL_W-1:0]  lo;
  logic [LVL_W-1:0]         span;
  logic [LVL_W-1:0]         pos;
  logic [LW-1:0]            level;

  logic signed [LVL_W-1:0]   target_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   sum_sat;
  logic signed [LVL_W:0]     span_full;
  logic signed [LVL_W:0]     pos_full;
  logic                      round_up;

  // Target in Q16.16
  assign target_q = $signed({14'd0, target, 8'd0});

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MS_SQ: begin
        mul_a = $signed({coef_square[COEF_W-1], coef_square});
        mul_b = $signed(MUL_B_W'(dsq));
      end
      MS_LIN: begin
        mul_a = $signed({coef_linear[COEF_W-1], coef_linear});
        mul_b = $signed(MUL_B_W'(d));
      end
      MS_SPAN_LO: begin
        mul_a = $signed({12'd0, span[SPLIT-1:0]});
        mul_b = $signed({2'd0, rnd});
      end
      MS_SPAN_HI: begin
        mul_a = $signed({12'd0, span[LVL_W-1:SPLIT]});
        mul_b = $signed({2'd0, rnd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Level sum and saturation to +-2^40
  assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign sum    = acc + prod_x;
  always_comb begin
    if (sum > LVL_SAT) begin
      sum_sat = LVL_SAT;
    end else if (sum < -LVL_SAT) begin
      sum_sat = -LVL_SAT;
    end else begin
      sum_sat = sum;
    end
  end

  // Span and position for the rounding test
  assign span_full = {lvl[LVL_W-1], lvl} - {lo[LVL_W-1], lo};
  assign pos_full  = {target_q[LVL_W-1], target_q} - {lo[LVL_W-1], lo};

  // Round up when r*span < pos*65536
  assign round_up = $unsigned(acc) < {2'd0, pos, 16'd0};

  assign stat.below     = lvl < target_q;
  assign stat.at_top    = d == TOP;
  assign stat.have_last = have_last;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      target <= target_in;
      rnd    <= rand_in;
      d      <= '0;
      dsq    <= '0;
    end

    if (ctrl.mul_sel != MS_NONE) begin
      prod <= PROD_W'(mul_a * mul_b);
    end

    case (ctrl.acc_op)
      AO_LOAD_CONST: acc <= {{(ACC_W-COEF_W){coef_const[COEF_W-1]}}, coef_const} + prod_x;
      AO_LOAD_PROD:  acc <= prod_x;
      AO_ADD_SHIFT:  acc <= acc + $signed({prod[ACC_W-SPLIT-1:0], SPLIT'(0)});
      default:       acc <= acc;
    endcase

    if (ctrl.lvl_load) begin
      lvl <= sum_sat[LVL_W-1:0];
    end

    // Level test: advance, finish at the top or at level zero, or set up rounding
    if (ctrl.br == BR_LEVEL) begin
      if (stat.below) begin
        lo <= lvl;
        if (stat.at_top) begin
          level <= d;
        end else begin
          d   <= d + 1'b1;
          dsq <= dsq + (2*LW)'({d, 1'b1});
        end
      end else if (!have_last) begin
        level <= '0;
      end else begin
        span <= span_full[LVL_W-1:0];
        pos  <= pos_full[LVL_W-1:0];
      end
    end

    // d sits one above the last level below the target
    if (ctrl.br == BR_ROUND) begin
      level <= round_up ? d : d - 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (start) begin
      have_last <= 1'b0;
    end else if (ctrl.br == BR_LEVEL && stat.below) begin
      have_last <= 1'b1;
    end
  end

  assign result = LEVEL_OUT_W'(level);

  a_lo_below_target: assert property (@(posedge clk) disable iff (rst)
    have_last |-> lo < target_q)
    else $error("stored lower level is not below the target");

  a_span_positive: assert property (@(posedge clk) disable iff (rst)
    (ctrl.mul_sel == MS_SPAN_LO) |-> span != '0)
    else $error("rounding span is zero");

endmodule

@@ design/weight_quantizer_stochastic_round.sv @@
// Top level of the stochastic-round weight quantizer: APB register file,
// input/output handshake and output register. Uses wqsr_seq, wqsr_dp, wqsr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries target_weight (unsigned Q12.8)
//   and random_fraction (r/65536). Output channel (out_valid / out_stall)
//   returns digital_level. A transfer happens on a clock edge with valid high
//   and stall low.
//   The three Q16.16 polynomial coefficients are written over the APB port at
//   byte addresses 0, 4 and 8; write them only while the block is idle.
//   Each item runs a microprogram over one shared 33x18 multiplier: four steps
//   per level tested, four steps for the rounding cross-multiply, plus accept
//   and emit steps. The walk tests up to NUM_LEVELS levels, and the rounding
//   steps are skipped when it ends at the top or at level zero. One item is
//   in work at a time; in_stall stays high until its result enters the output
//   register, so a new item can be taken while that result still waits.
//   When the receiver stalls, the result is held in the output register and
//   the next result waits in the emit step.
//   Reset (rst, synchronous) returns the sequencer to idle, empties the output
//   register and loads the default calibration coefficients.
module weight_quantizer_stochastic_round import wqsr_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TARGET_W-1:0]    target_weight,
  input  logic [RAND_W-1:0]      random_fraction,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_OUT_W-1:0] digital_level,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [COEF_W-1:0]      pwdata,
  output logic [COEF_W-1:0]      prdata,
  output logic                   pready
);

  logic signed [COEF_W-1:0] coef_const;
  logic signed [COEF_W-1:0] coef_linear;
  logic signed [COEF_W-1:0] coef_square;
  logic                     start;
  logic                     out_free;
  logic                     emit;
  ucode_t                   ctrl;
  dp_stat_t                 stat;
  logic [LEVEL_OUT_W-1:0]   result;
  logic                     wr_en;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_const  <= COEF_CONST_RST;
      coef_linear <= COEF_LINEAR_RST;
      coef_square <= COEF_SQUARE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_COEF_CONST:  coef_const  <= pwdata;
        REG_COEF_LINEAR: coef_linear <= pwdata;
        REG_COEF_SQUARE: coef_square <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COEF_CONST:  prdata = coef_const;
      REG_COEF_LINEAR: prdata = coef_linear;
      REG_COEF_SQUARE: prdata = coef_square;
      default:         prdata = '0;
    endcase
  end

  // Handshake
  assign in_stall = ctrl.br != BR_START;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit     = (ctrl.br == BR_EMIT) && out_free;

  wqsr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  wqsr_dp #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .start       (start),
    .target_in   (target_weight),
    .rand_in     (random_fraction),
    .coef_const  (coef_const),
    .coef_linear (coef_linear),
    .coef_square (coef_square),
    .stat        (stat),
    .result      (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digital_level <= result;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("sequencer did not start on an input transfer");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.br == BR_EMIT))
    else $error("output register loaded outside the emit step");

endmodule
